FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared implication checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JSS_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define JSS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// Command codes, status codes and the front-to-back control record.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

    // command modes; the back end keeps the running command under the same code
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_RESET = 3'd1;
    localparam logic [2:0] MODE_IR    = 3'd2;
    localparam logic [2:0] MODE_DR    = 3'd3;
    localparam logic [2:0] MODE_CH1   = 3'd4;
    localparam logic [2:0] MODE_CH2   = 3'd5;

    localparam logic [1:0] ST_CYCLE  = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;

    localparam int BIT_COUNT_BITS = 6;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic [2:0]                kind;
        logic                      bad_len;
        logic [BIT_COUNT_BITS-1:0] bit_count;
        logic                      debug_break;
        logic                      write_flag;
        logic                      tdo_sample;
    } jss_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/jss_if.sv
// ----------------------------------------------------------------------------
// JTAG sequencer channel interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_cmd_if #(
    parameter int WORD_BITS     = 32,
    parameter int ICE_ADDR_BITS = 5
);
    logic                     valid;
    logic                     ready;
    logic [2:0]               mode;
    logic [5:0]               bit_count;
    logic [WORD_BITS-1:0]     shift_data;
    logic                     debug_break;
    logic [ICE_ADDR_BITS-1:0] ice_address;
    logic                     write_flag;
    logic                     tdo_sample;

    modport source
    (
        output valid, mode, bit_count, shift_data, debug_break, ice_address,
               write_flag, tdo_sample,
        input  ready
    );
    modport sink
    (
        input  valid, mode, bit_count, shift_data, debug_break, ice_address,
               write_flag, tdo_sample,
        output ready
    );
endinterface

interface jss_rsp_if #(
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 tms_level;
    logic                 tdi_level;
    logic                 command_done;
    logic [WORD_BITS-1:0] captured_word;
    logic [1:0]           status;

    modport source
    (
        output valid, tms_level, tdi_level, command_done, captured_word, status,
        input  ready
    );
    modport sink
    (
        input  valid, tms_level, tdi_level, command_done, captured_word, status,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/jtag_scan_sequencer.sv
// ----------------------------------------------------------------------------
// jtag_scan_sequencer
// JTAG master: reset, IR/DR scans and debug chain 1/2 accesses, one TCK
// period per tick transaction.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction carries
//  -------  ---  -----------------------------------------------------------
//  cmd      in   mode, bit_count, shift_data, debug_break, ice_address,
//                write_flag, tdo_sample
//  rsp      out  tms_level, tdi_level, command_done, captured_word, status
//
//  One cmd transaction per clock sustained while the queue has room; an
//  accepted transaction is written into the queue, and its result, if any,
//  is loaded into the rsp register at the edge where the back end pops it.
//  The back end retires one queue entry per clock while its single result
//  register is empty or taken; each busy tick moves the TAP walk one phase.
//  Reset clears the sequencer and both queue pointers; no clearing pass.
//  rsp.ready low holds the result; the two-entry queue then fills and
//  cmd.ready drops.
//
`default_nettype none

module jtag_scan_sequencer import jss_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int ICE_ADDR_BITS = 5
) (
    input  logic      clk,
    input  logic      rst_n,
    jss_cmd_if.sink   cmd,
    jss_rsp_if.source rsp
);

    localparam int QW = $bits(jss_ctl_t) + WORD_BITS + ICE_ADDR_BITS;

    // front end to queue
    logic                     f_push;
    jss_ctl_t                 f_ctl;
    logic [WORD_BITS-1:0]     f_data;
    logic [ICE_ADDR_BITS-1:0] f_addr;
    logic [QW-1:0]            q_wr_data;
    logic                     q_full;

    // queue to back end
    logic                     q_valid;
    logic                     q_pop;
    logic [QW-1:0]            q_rd_data;
    jss_ctl_t                 b_ctl;
    logic [WORD_BITS-1:0]     b_data;
    logic [ICE_ADDR_BITS-1:0] b_addr;

    // front: decodes mode, flags a bad scan length up front
    jss_front #(
        .WORD_BITS     (WORD_BITS),
        .ICE_ADDR_BITS (ICE_ADDR_BITS)
    ) u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push   (f_push),
        .ctl    (f_ctl),
        .data   (f_data),
        .addr   (f_addr)
    );

    assign q_wr_data = {f_ctl, f_data, f_addr};

    jss_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rd_data)
    );

    assign {b_ctl, b_data, b_addr} = q_rd_data;

    // back: busy/reject decisions and the TAP walk live here, in order
    jss_back #(
        .WORD_BITS     (WORD_BITS),
        .ICE_ADDR_BITS (ICE_ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .ctl     (b_ctl),
        .data    (b_data),
        .addr    (b_addr),
        .pop     (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/jss_front.sv
// ----------------------------------------------------------------------------
// jss_front
// Takes command transactions, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_front import jss_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int ICE_ADDR_BITS = 5
) (
    jss_cmd_if.sink                  cmd,
    input  logic                     q_full,
    output logic                     push,
    output jss_ctl_t                 ctl,
    output logic [WORD_BITS-1:0]     data,
    output logic [ICE_ADDR_BITS-1:0] addr
);

    logic is_cmd;
    logic is_scan;

    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

    // modes 6 and 7 run as clock ticks
    assign is_cmd  = cmd.mode inside {[MODE_RESET:MODE_CH2]};
    assign is_scan = cmd.mode inside {MODE_IR, MODE_DR};

    always_comb
    begin
        ctl.op          = is_cmd ? OP_CMD : OP_TICK;
        ctl.kind        = cmd.mode;
        ctl.bad_len     = is_scan &&
                          (cmd.bit_count == '0 || 32'(cmd.bit_count) > WORD_BITS);
        ctl.bit_count   = cmd.bit_count;
        ctl.debug_break = cmd.debug_break;
        ctl.write_flag  = cmd.write_flag;
        ctl.tdo_sample  = cmd.tdo_sample;
    end

    assign data = cmd.shift_data;
    assign addr = cmd.ice_address;

endmodule

`default_nettype wire

FILE: hdl/jss_queue.sv
// ----------------------------------------------------------------------------
// jss_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jss_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign pop_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'(DEPTH);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JSS_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue count did not grow on push")

endmodule

`default_nettype wire

FILE: hdl/jss_back.sv
// ----------------------------------------------------------------------------
// jss_back
// Runs the TAP sequences one TCK cycle per tick and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jss_back import jss_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int ICE_ADDR_BITS = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  jss_ctl_t                 ctl,
    input  logic [WORD_BITS-1:0]     data,
    input  logic [ICE_ADDR_BITS-1:0] addr,
    output logic                     pop,
    jss_rsp_if.source                rsp
);

    localparam int PW = $clog2(WORD_BITS + ICE_ADDR_BITS + 8);
    localparam int IW = $clog2(WORD_BITS);

    // sequencer state
    logic                     busy_reg, busy_next;
    logic [2:0]               kind_reg, kind_next;
    logic [PW-1:0]            phase_reg, phase_next;
    logic [PW-1:0]            len_reg, len_next;
    logic [WORD_BITS-1:0]     out_reg, out_next;
    logic [WORD_BITS-1:0]     in_reg, in_next;
    logic [ICE_ADDR_BITS-1:0] addr_reg, addr_next;
    logic                     brk_reg, brk_next;
    logic                     wr_reg, wr_next;

    // result register
    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     rsp_tms_reg, rsp_tms_next;
    logic                     rsp_tdi_reg, rsp_tdi_next;
    logic                     rsp_done_reg, rsp_done_next;
    logic [WORD_BITS-1:0]     rsp_word_reg, rsp_word_next;
    logic [1:0]               rsp_status_reg, rsp_status_next;

    // current TCK cycle
    logic                     cyc_tms, cyc_tdi, cyc_last;
    logic                     shift_right, shift_left, shift_addr;
    logic                     cap_dr, cap_ch1;
    logic [PW-1:0]            pre_len, shift_end, phase_off, a0, wbp;
    logic [IW-1:0]            cap_idx;

    assign pre_len   = (kind_reg == MODE_IR) ? PW'(4) : PW'(3);
    assign shift_end = pre_len + len_reg;
    assign phase_off = phase_reg - pre_len;
    assign cap_idx   = phase_off[IW-1:0];
    assign a0        = wr_reg ? PW'(WORD_BITS + 3) : PW'(3);
    assign wbp       = a0 + PW'(ICE_ADDR_BITS);

    always_comb
    begin
        cyc_tms     = 1'b0;
        cyc_tdi     = 1'b0;
        cyc_last    = 1'b1;
        shift_right = 1'b0;
        shift_left  = 1'b0;
        shift_addr  = 1'b0;
        cap_dr      = 1'b0;
        cap_ch1     = 1'b0;
        case (kind_reg)
            MODE_RESET:
            begin
                cyc_tms  = phase_reg < PW'(5);
                cyc_last = phase_reg >= PW'(5);
            end
            MODE_IR, MODE_DR:
            begin
                if (phase_reg < pre_len)
                begin
                    cyc_tms = phase_reg == '0 ||
                              (phase_reg == PW'(1) && kind_reg == MODE_IR);
                end
                else if (phase_reg < shift_end)
                begin
                    cyc_tdi     = out_reg[0];
                    cyc_tms     = phase_reg == shift_end - PW'(1);
                    shift_right = 1'b1;
                    cap_dr      = kind_reg == MODE_DR;
                end
                else
                begin
                    cyc_tms = phase_reg == shift_end;
                end
                cyc_last = phase_reg == shift_end + PW'(1);
            end
            MODE_CH1:
            begin
                if (phase_reg < PW'(3))
                begin
                    cyc_tms = phase_reg == '0;
                end
                else if (phase_reg == PW'(3))
                begin
                    cyc_tdi = brk_reg;
                end
                else if (phase_reg < PW'(WORD_BITS + 4))
                begin
                    cyc_tdi    = out_reg[WORD_BITS-1];
                    cyc_tms    = phase_reg == PW'(WORD_BITS + 3);
                    shift_left = 1'b1;
                    cap_ch1    = 1'b1;
                end
                else
                begin
                    cyc_tms = phase_reg == PW'(WORD_BITS + 4);
                end
                cyc_last = phase_reg == PW'(WORD_BITS + 5);
            end
            MODE_CH2:
            begin
                if (phase_reg < PW'(3))
                begin
                    cyc_tms = phase_reg == '0;
                end
                else if (phase_reg < a0)
                begin
                    cyc_tdi     = out_reg[0];
                    shift_right = 1'b1;
                end
                else if (phase_reg < wbp)
                begin
                    cyc_tdi    = addr_reg[0];
                    shift_addr = 1'b1;
                end
                else if (phase_reg == wbp)
                begin
                    cyc_tms = 1'b1;
                    cyc_tdi = wr_reg;
                end
                else
                begin
                    cyc_tms = phase_reg == wbp + PW'(1);
                end
                cyc_last = phase_reg == wbp + PW'(2);
            end
            default:
            begin
            end
        endcase
    end

    assign pop = q_valid && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        busy_next       = busy_reg;
        kind_next       = kind_reg;
        phase_next      = phase_reg;
        len_next        = len_reg;
        out_next        = out_reg;
        in_next         = in_reg;
        addr_next       = addr_reg;
        brk_next        = brk_reg;
        wr_next         = wr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_tms_next    = rsp_tms_reg;
        rsp_tdi_next    = rsp_tdi_reg;
        rsp_done_next   = rsp_done_reg;
        rsp_word_next   = rsp_word_reg;
        rsp_status_next = rsp_status_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b0;
            if (ctl.op == OP_CMD)
            begin
                if (busy_reg || ctl.bad_len)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_tms_next    = 1'b0;
                    rsp_tdi_next    = 1'b0;
                    rsp_done_next   = 1'b0;
                    rsp_word_next   = '0;
                    rsp_status_next = busy_reg ? ST_BUSY : ST_BADLEN;
                end
                else
                begin
                    busy_next  = 1'b1;
                    kind_next  = ctl.kind;
                    phase_next = '0;
                    len_next   = PW'(ctl.bit_count);
                    out_next   = data;
                    in_next    = '0;
                    addr_next  = addr;
                    brk_next   = ctl.debug_break;
                    wr_next    = ctl.write_flag;
                end
            end
            else if (busy_reg)
            begin
                rsp_valid_next  = 1'b1;
                rsp_tms_next    = cyc_tms;
                rsp_tdi_next    = cyc_tdi;
                rsp_done_next   = cyc_last;
                rsp_status_next = ST_CYCLE;
                rsp_word_next   = (cyc_last && (kind_reg == MODE_DR || kind_reg == MODE_CH1))
                                  ? in_reg : '0;
                if (cyc_last)
                begin
                    busy_next  = 1'b0;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + PW'(1);
                end
                if (shift_right)
                begin
                    out_next = out_reg >> 1;
                end
                if (shift_left)
                begin
                    out_next = out_reg << 1;
                end
                if (shift_addr)
                begin
                    addr_next = addr_reg >> 1;
                end
                if (cap_dr)
                begin
                    in_next[cap_idx] = ctl.tdo_sample;
                end
                if (cap_ch1)
                begin
                    in_next = {in_reg[WORD_BITS-2:0], ctl.tdo_sample};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= MODE_TICK;
            phase_reg     <= '0;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        in_reg         <= in_next;
        addr_reg       <= addr_next;
        brk_reg        <= brk_next;
        wr_reg         <= wr_next;
        rsp_tms_reg    <= rsp_tms_next;
        rsp_tdi_reg    <= rsp_tdi_next;
        rsp_done_reg   <= rsp_done_next;
        rsp_word_reg   <= rsp_word_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.tms_level     = rsp_tms_reg;
    assign rsp.tdi_level     = rsp_tdi_reg;
    assign rsp.command_done  = rsp_done_reg;
    assign rsp.captured_word = rsp_word_reg;
    assign rsp.status        = rsp_status_reg;

    `JSS_ASSERT_IMPL(a_idle_phase, !busy_reg, phase_reg == '0, "phase moved while idle")
    `JSS_ASSERT_IMPL(a_done_ends, $fell(busy_reg), rsp_valid_reg && rsp_done_reg, "command ended without done")
    `JSS_ASSERT_IMPL(a_word_on_done, rsp_valid_reg && !rsp_done_reg, rsp_word_reg == '0, "capture word outside done")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for jtag_scan_sequencer. A queue of command and tick
// transactions is driven with random gaps; every accepted transaction runs
// through a local model of the TAP walk, and each result on the rsp channel
// is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
    import jss_pkg::*;

    localparam int SCAN_WORD   = 32;
    localparam int ICE_BITS    = 5;
    localparam int MAX_WAIT    = 18;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_TICKS = 20;
    localparam int RANDOM_ITEMS = 1150;

    // modes 6 and 7 are unused codes; the sequencer treats them as ticks
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // one cmd transaction
    typedef struct packed
    {
        logic [2:0]           mode;
        logic [5:0]           bit_count;
        logic [SCAN_WORD-1:0] shift_data;
        logic                 debug_break;
        logic [ICE_BITS-1:0]  ice_address;
        logic                 write_flag;
        logic                 tdo_sample;
    } scan_item_t;

    // one rsp transaction
    typedef struct packed
    {
        logic                 tms_level;
        logic                 tdi_level;
        logic                 command_done;
        logic [SCAN_WORD-1:0] captured_word;
        logic [1:0]           status;
    } pin_result_t;

    logic clk;
    logic rst_n;

    jss_cmd_if #(.WORD_BITS(SCAN_WORD), .ICE_ADDR_BITS(ICE_BITS)) cmd_ch ();
    jss_rsp_if #(.WORD_BITS(SCAN_WORD)) rsp_ch ();

    jtag_scan_sequencer #(
        .WORD_BITS    (SCAN_WORD),
        .ICE_ADDR_BITS(ICE_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    scan_item_t  pending_scans[$];     // stimulus not yet offered
    pin_result_t expected_levels[$];   // predicted results, oldest first
    int          error_count = 0;
    int          cycle_count = 0;

    // ------------------------------------------------------------------
    // Local copy of the sequencer state
    // ------------------------------------------------------------------
    bit                   tap_busy;
    logic [2:0]           tap_kind;
    int unsigned          tap_phase;
    int unsigned          tap_len;
    logic [SCAN_WORD-1:0] tap_out;
    logic [SCAN_WORD-1:0] tap_in;
    logic [ICE_BITS-1:0]  tap_addr;
    logic                 tap_break;
    logic                 tap_write;

    // Applies one accepted transaction to the local state; flags whether
    // it yields a result and what that result is.
    task automatic advance_tap_walk(input scan_item_t it, output bit produced,
                                    output pin_result_t res);
        int unsigned p;
        int unsigned pre;
        int unsigned idx;
        int unsigned a0;
        int unsigned wb;
        bit          last;
        res      = '0;
        produced = 1'b0;
        last     = 1'b0;
        if (it.mode >= MODE_RESET && it.mode <= MODE_CH2)
        begin
            // command: rejected while busy or on a bad length, else loaded
            if (tap_busy)
            begin
                res.status = ST_BUSY;
                produced   = 1'b1;
            end
            else if ((it.mode == MODE_IR || it.mode == MODE_DR) &&
                     (it.bit_count == 0 || it.bit_count > SCAN_WORD))
            begin
                res.status = ST_BADLEN;
                produced   = 1'b1;
            end
            else
            begin
                tap_busy  = 1'b1;
                tap_kind  = it.mode;
                tap_phase = 0;
                tap_len   = 32'(it.bit_count);
                tap_out   = it.shift_data;
                tap_in    = '0;
                tap_addr  = it.ice_address;
                tap_break = it.debug_break;
                tap_write = it.write_flag;
            end
            return;
        end
        // tick (or spare mode): idle ticks give nothing
        if (!tap_busy)
            return;
        produced = 1'b1;
        p        = tap_phase;
        case (tap_kind)
            MODE_RESET:
            begin
                res.tms_level = (p < 5);
                last          = (p >= 5);
            end
            MODE_IR, MODE_DR:
            begin
                pre = (tap_kind == MODE_IR) ? 4 : 3;
                if (p < pre)
                    res.tms_level = (p == 0) || (p == 1 && tap_kind == MODE_IR);
                else if (p < pre + tap_len)
                begin
                    idx           = p - pre;
                    res.tdi_level = tap_out[idx];
                    res.tms_level = (idx == tap_len - 1);
                    if (tap_kind == MODE_DR)
                        tap_in[idx] = tap_in[idx] | it.tdo_sample;
                end
                else
                    res.tms_level = (p == pre + tap_len);
                last = (p >= pre + tap_len + 1);
            end
            MODE_CH1:
            begin
                if (p < 3)
                    res.tms_level = (p == 0);
                else if (p == 3)
                    res.tdi_level = tap_break;
                else if (p < 4 + SCAN_WORD)
                begin
                    idx           = p - 4;
                    res.tdi_level = tap_out[SCAN_WORD - 1 - idx];
                    res.tms_level = (idx == SCAN_WORD - 1);
                    tap_in        = {tap_in[SCAN_WORD-2:0], it.tdo_sample};
                end
                else
                    res.tms_level = (p == 4 + SCAN_WORD);
                last = (p >= 5 + SCAN_WORD);
            end
            default:
            begin
                // chain 2: data only on a write, then address, then write bit
                a0 = 3 + (tap_write ? SCAN_WORD : 0);
                wb = a0 + ICE_BITS;
                if (p < 3)
                    res.tms_level = (p == 0);
                else if (p < a0)
                    res.tdi_level = tap_out[p - 3];
                else if (p < wb)
                    res.tdi_level = tap_addr[p - a0];
                else if (p == wb)
                begin
                    res.tms_level = 1'b1;
                    res.tdi_level = tap_write;
                end
                else
                    res.tms_level = (p == wb + 1);
                last = (p >= wb + 2);
            end
        endcase
        res.command_done = last;
        if (last)
        begin
            if (tap_kind == MODE_DR || tap_kind == MODE_CH1)
                res.captured_word = tap_in;
            tap_busy  = 1'b0;
            tap_phase = 0;
        end
        else
            tap_phase++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Ticks a well-formed command needs to run to completion.
    function automatic int scan_ticks(input scan_item_t c);
        case (c.mode)
            MODE_RESET: return 6;
            MODE_IR:    return (c.bit_count == 0 || c.bit_count > SCAN_WORD) ? 0 : 6 + c.bit_count;
            MODE_DR:    return (c.bit_count == 0 || c.bit_count > SCAN_WORD) ? 0 : 5 + c.bit_count;
            MODE_CH1:   return SCAN_WORD + 6;
            MODE_CH2:   return (c.write_flag ? SCAN_WORD : 0) + ICE_BITS + 6;
            default:    return 0;
        endcase
    endfunction

    // Tick with random filler in every field; now and then a spare mode.
    function automatic scan_item_t make_tick();
        scan_item_t t;
        t.mode        = MODE_TICK;
        t.bit_count   = 6'($urandom_range(0, 63));
        t.shift_data  = $urandom;
        t.debug_break = 1'($urandom_range(0, 1));
        t.ice_address = 5'($urandom_range(0, 31));
        t.write_flag  = 1'($urandom_range(0, 1));
        t.tdo_sample  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0)
            t.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        return t;
    endfunction

    function automatic scan_item_t make_command(input logic [2:0] mode,
                                                input logic [5:0] count,
                                                input logic [SCAN_WORD-1:0] data,
                                                input logic brk,
                                                input logic [ICE_BITS-1:0] addr,
                                                input logic wr);
        scan_item_t c;
        c.mode        = mode;
        c.bit_count   = count;
        c.shift_data  = data;
        c.debug_break = brk;
        c.ice_address = addr;
        c.write_flag  = wr;
        c.tdo_sample  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Random command; IR/DR lengths are mostly legal, sometimes 0 or > 32.
    function automatic scan_item_t random_command();
        logic [2:0] m;
        logic [5:0] n;
        m = 3'($urandom_range(MODE_RESET, MODE_CH2));
        n = 6'($urandom_range(0, 63));
        if (m == MODE_IR || m == MODE_DR)
        begin
            if ($urandom_range(0, 9) != 0)
                n = 6'($urandom_range(1, SCAN_WORD));
            else
                n = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
        end
        return make_command(m, n, $urandom, 1'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endfunction

    // Queues a command and the ticks that finish it; busy_pct is the chance,
    // per tick, of a stray command landing mid-walk (rejected as busy).
    task automatic add_sequence(input scan_item_t c, input int busy_pct,
                                inout int queued);
        int n;
        n = scan_ticks(c);
        pending_scans.push_back(c);
        queued++;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < busy_pct)
            begin
                pending_scans.push_back(random_command());
                queued++;
            end
            pending_scans.push_back(make_tick());
            queued++;
        end
    endtask

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    // One line per mismatch; printing is capped so a broken build stays readable.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 100)
            $display("ERROR @%0d cycles: %s", cycle_count, what);
    endtask

    // Wait before the next transaction; quiet stretches run back to back.
    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic drive_payload(input scan_item_t it);
        cmd_ch.mode        <= it.mode;
        cmd_ch.bit_count   <= it.bit_count;
        cmd_ch.shift_data  <= it.shift_data;
        cmd_ch.debug_break <= it.debug_break;
        cmd_ch.ice_address <= it.ice_address;
        cmd_ch.write_flag  <= it.write_flag;
        cmd_ch.tdo_sample  <= it.tdo_sample;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the stimulus plan
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        scan_item_t t;
        int         queued;
        int         pick;
        queued = 0;
        rst_n  = 1'b0;

        // directed: idle ticks in all three tick codes give no result
        t = make_tick();
        t.mode = MODE_TICK;
        pending_scans.push_back(t);
        t.mode = MODE_SPARE_A;
        pending_scans.push_back(t);
        t.mode = MODE_SPARE_B;
        pending_scans.push_back(t);
        // TAP reset, the second one with stray commands rejected as busy
        add_sequence(make_command(MODE_RESET, 6'd0, '0, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_RESET, 6'd63, '1, 1'b1, '1, 1'b1), 30, queued);
        // shortest and longest IR and DR scans, plus a mid-length DR scan
        add_sequence(make_command(MODE_IR, 6'd1, '1, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_IR, 6'd32, 32'h5a5a_c3c3, 1'b1, '1, 1'b1), 0, queued);
        add_sequence(make_command(MODE_DR, 6'd32, '0, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_DR, 6'd1, '1, 1'b1, '1, 1'b1), 0, queued);
        add_sequence(make_command(MODE_DR, 6'd17, $urandom, 1'b0, '0, 1'b0), 0, queued);
        // bad lengths: zero, just past the word, all ones
        add_sequence(make_command(MODE_IR, 6'd0, '1, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_DR, 6'd33, '1, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_IR, 6'd63, '0, 1'b0, '0, 1'b0), 0, queued);
        // chain 1 with both break values
        add_sequence(make_command(MODE_CH1, 6'd0, 32'h8000_0001, 1'b0, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_CH1, 6'd0, '1, 1'b1, '1, 1'b0), 20, queued);
        // chain 2 write and read at the address extremes, then a read mid-range
        add_sequence(make_command(MODE_CH2, 6'd0, $urandom, 1'b0, '1, 1'b1), 0, queued);
        add_sequence(make_command(MODE_CH2, 6'd0, '1, 1'b1, '0, 1'b0), 0, queued);
        add_sequence(make_command(MODE_CH2, 6'd0, $urandom, 1'b0, 5'd21, 1'b0), 10, queued);

        // random: mostly complete walks with random payload and TDO, the
        // rest noise (idle ticks, lone bad-length commands, stray commands)
        while (queued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
                add_sequence(random_command(), ($urandom_range(0, 3) == 0) ? 15 : 0, queued);
            else if (pick < 90)
            begin
                t = make_command($urandom_range(0, 1) ? MODE_IR : MODE_DR,
                                 $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)),
                                 $urandom, 1'($urandom_range(0, 1)),
                                 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                add_sequence(t, 0, queued);
            end
            else
            begin
                // ignored idle ticks
                repeat ($urandom_range(1, 3))
                begin
                    pending_scans.push_back(make_tick());
                    queued++;
                end
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // all stimulus accepted and every predicted result seen
        while (pending_scans.size() != 0 || cmd_ch.valid || expected_levels.size() != 0)
            @(posedge clk);
        // results reach the rsp register when the back end pops them; allow slack for strays
        repeat (DRAIN_TICKS) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_levels.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop in case the handshake locks up.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the queued transactions on cmd, predicts on accept
    // ------------------------------------------------------------------
    scan_item_t  offered_scan;
    int          cmd_gap;
    bit          cmd_quiet;
    bit          cmd_valid_next;
    bit          produced_result;
    pin_result_t predicted_levels;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            drive_payload('0);
            cmd_gap   = 0;
            cmd_quiet = 1'b0;
            tap_busy  = 1'b0;
            tap_kind  = MODE_TICK;
            tap_phase = 0;
            tap_len   = 0;
            tap_out   = '0;
            tap_in    = '0;
            tap_addr  = '0;
            tap_break = 1'b0;
            tap_write = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                // transaction taken at this edge
                advance_tap_walk(offered_scan, produced_result, predicted_levels);
                if (produced_result)
                    expected_levels.push_back(predicted_levels);
                cmd_valid_next = 1'b0;
                cmd_gap        = draw_wait(cmd_quiet);
                if ($urandom_range(0, 59) == 0)
                    cmd_quiet = ~cmd_quiet;
            end
            if (!cmd_valid_next)
            begin
                if (cmd_gap > 0)
                    cmd_gap--;
                else if (pending_scans.size() != 0)
                begin
                    offered_scan = pending_scans.pop_front();
                    drive_payload(offered_scan);
                    cmd_valid_next = 1'b1;
                end
            end
            cmd_ch.valid <= cmd_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on rsp, checks each taken result
    // ------------------------------------------------------------------
    int          rsp_stall;
    bit          rsp_quiet;
    bit          rsp_ready_next;
    pin_result_t seen_levels;
    pin_result_t wanted_levels;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
            rsp_quiet = 1'b0;
        end
        else
        begin
            rsp_ready_next = rsp_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_levels.tms_level     = rsp_ch.tms_level;
                seen_levels.tdi_level     = rsp_ch.tdi_level;
                seen_levels.command_done  = rsp_ch.command_done;
                seen_levels.captured_word = rsp_ch.captured_word;
                seen_levels.status        = rsp_ch.status;
                if (expected_levels.size() == 0)
                    report_mismatch("result with no prediction pending");
                else
                begin
                    wanted_levels = expected_levels.pop_front();
                    if (seen_levels.tms_level !== wanted_levels.tms_level)
                        report_mismatch($sformatf("tms_level %b, expected %b",
                            seen_levels.tms_level, wanted_levels.tms_level));
                    if (seen_levels.tdi_level !== wanted_levels.tdi_level)
                        report_mismatch($sformatf("tdi_level %b, expected %b",
                            seen_levels.tdi_level, wanted_levels.tdi_level));
                    if (seen_levels.command_done !== wanted_levels.command_done)
                        report_mismatch($sformatf("command_done %b, expected %b",
                            seen_levels.command_done, wanted_levels.command_done));
                    if (seen_levels.captured_word !== wanted_levels.captured_word)
                        report_mismatch($sformatf("captured_word %h, expected %h",
                            seen_levels.captured_word, wanted_levels.captured_word));
                    if (seen_levels.status !== wanted_levels.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            seen_levels.status, wanted_levels.status));
                end
                // stall before the next result
                rsp_stall      = draw_wait(rsp_quiet);
                rsp_ready_next = (rsp_stall == 0);
                if ($urandom_range(0, 59) == 0)
                    rsp_quiet = ~rsp_quiet;
            end
            else if (!rsp_ch.ready)
            begin
                if (rsp_stall > 0)
                    rsp_stall--;
                rsp_ready_next = (rsp_stall == 0);
            end
            rsp_ch.ready <= rsp_ready_next;
        end
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/jss_pkg.sv
hdl/jss_if.sv
hdl/jss_front.sv
hdl/jss_queue.sv
hdl/jss_back.sv
hdl/jtag_scan_sequencer.sv
bench/tb_top.sv
